// ===== sv/cas_pkg.sv =====
`timescale 1ns / 1ps

package cas_pkg;

    typedef struct packed {
        logic [11:0] start_year;
        logic [3:0]  start_month;
        logic [4:0]  start_day;
        logic [4:0]  start_hour;
        logic [5:0]  start_minute;
        logic [5:0]  start_second;
        logic [31:0] offset_seconds;
    } t_in;

    typedef struct packed {
        logic [11:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
        logic [2:0]  out_weekday;
        logic [31:0] total_seconds;
    } t_out;

    localparam logic [11:0] EPOCH_YEAR     = 12'd2000;
    localparam logic [11:0] CENTURY_YEAR   = 12'd2100;
    localparam logic [11:0] LAST_YEAR      = 12'd2136;
    localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
    localparam logic [8:0]  DAYS_LEAP_YEAR = 9'd366;
    localparam logic [10:0] DAYS_PER_BLOCK = 11'd1461;
    localparam logic [10:0] DAYS_SHORT_BLK = 11'd1460;
    localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
    localparam logic [3:0]  MONTH_JAN      = 4'd1;
    localparam logic [3:0]  MONTH_FEB      = 4'd2;
    localparam logic [3:0]  MONTH_MAR      = 4'd3;
    localparam logic [3:0]  MONTH_DEC      = 4'd12;

    // Reciprocals for constant division; each estimate is low by at most one.
    localparam logic [13:0] RECIP_100      = 14'd5243;
    localparam logic [14:0] RECIP_675      = 15'd24855;
    localparam logic [8:0]  RECIP_225      = 9'd291;
    localparam logic [12:0] RECIP_15       = 13'd4369;

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd365;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    // Eight is one modulo seven, so three-bit digits may simply be summed.
    function automatic logic [2:0] mod7(input logic [16:0] v);
        logic [17:0] w;
        logic [5:0]  s1;
        logic [3:0]  s2;
        w  = {1'b0, v};
        s1 = '0;
        for (int k = 0; k < 6; k++) begin
            s1 = s1 + 6'(w[3*k +: 3]);
        end
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        if (s2 >= 4'd7) begin
            s2 = s2 - 4'd7;
        end
        return s2[2:0];
    endfunction

endpackage

// ===== sv/cas_front.sv =====
`timescale 1ns / 1ps

module cas_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  cas_pkg::t_in   i_data,
    output logic           o_push,
    output logic [31:0]    o_total,
    input  logic           i_full
);

    localparam logic [2:0] FS_IDLE = 3'd0;
    localparam logic [2:0] FS_DIV  = 3'd1;
    localparam logic [2:0] FS_SUM  = 3'd2;
    localparam logic [2:0] FS_MUL  = 3'd3;
    localparam logic [2:0] FS_ADD  = 3'd4;
    localparam logic [2:0] FS_PUSH = 3'd5;

    logic [2:0]   r_state;
    cas_pkg::t_in r_in;
    logic [11:0]  r_n;
    logic [9:0]   r_c4;
    logic [4:0]   r_q100;
    logic [2:0]   r_q400;
    logic [5:0]   r_qy;
    logic [31:0]  r_days;
    logic [16:0]  r_hms;
    logic [31:0]  r_prod;
    logic [31:0]  r_total;

    logic [11:0]  w_n;
    logic [11:0]  w_a100;
    logic [9:0]   w_a400;
    logic [25:0]  w_p100;
    logic [23:0]  w_p400;
    logic [25:0]  w_py;
    logic [9:0]   w_leaps;
    logic [19:0]  w_yd;
    logic         w_m100;
    logic         w_leap;
    logic [8:0]   w_md;

    always_comb begin
        w_n     = (r_in.start_year > cas_pkg::EPOCH_YEAR) ?
                  r_in.start_year - cas_pkg::EPOCH_YEAR : 12'd0;
        w_a100  = w_n + 12'd99;
        w_a400  = 10'((w_n + 12'd399) >> 2);
        w_p100  = 26'(w_a100) * 26'(cas_pkg::RECIP_100);
        w_p400  = 24'(w_a400) * 24'(cas_pkg::RECIP_100);
        w_py    = 26'(r_in.start_year) * 26'(cas_pkg::RECIP_100);
        w_leaps = r_c4 - 10'(r_q100) + 10'(r_q400);
        w_yd    = 20'(r_n) * 20'(cas_pkg::DAYS_PER_YEAR) + 20'(w_leaps);
        w_m100  = (r_in.start_year == 12'(13'(r_qy) * 13'd100));
        w_leap  = ((r_in.start_year[1:0] == 2'd0) && !w_m100) ||
                  (w_m100 && (r_qy[1:0] == 2'd0));
        w_md    = cas_pkg::days_before(r_in.start_month) +
                  9'(w_leap && (r_in.start_month >= cas_pkg::MONTH_MAR));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            unique case (r_state)
                FS_IDLE: begin
                    if (i_valid) begin
                        r_state <= FS_DIV;
                    end
                end
                FS_DIV:  r_state <= FS_SUM;
                FS_SUM:  r_state <= FS_MUL;
                FS_MUL:  r_state <= FS_ADD;
                FS_ADD:  r_state <= FS_PUSH;
                FS_PUSH: begin
                    if (!i_full) begin
                        r_state <= FS_IDLE;
                    end
                end
                default: r_state <= FS_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == FS_IDLE && i_valid) begin
            r_in <= i_data;
        end
        if (r_state == FS_DIV) begin
            r_n    <= w_n;
            r_c4   <= 10'((w_n + 12'd3) >> 2);
            r_q100 <= w_p100[23:19];
            r_q400 <= w_p400[21:19];
            r_qy   <= w_py[24:19];
        end
        if (r_state == FS_SUM) begin
            r_days <= 32'(w_yd) + 32'(w_md) + 32'(r_in.start_day) - 32'd1;
            r_hms  <= 17'(r_in.start_hour) * 17'(cas_pkg::SECS_PER_HOUR) +
                      17'(r_in.start_minute) * 17'(cas_pkg::SECS_PER_MIN) +
                      17'(r_in.start_second);
        end
        if (r_state == FS_MUL) begin
            r_prod <= r_days * 32'(cas_pkg::SECS_PER_DAY);
        end
        if (r_state == FS_ADD) begin
            r_total <= r_prod + 32'(r_hms) + r_in.offset_seconds;
        end
    end

    assign o_stall = (r_state != FS_IDLE);
    assign o_push  = (r_state == FS_PUSH) && !i_full;
    assign o_total = r_total;

endmodule

// ===== sv/cas_queue.sv =====
`timescale 1ns / 1ps

module cas_queue #(
    parameter int DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [31:0] i_data,
    output logic        o_full,
    input  logic        i_pop,
    output logic [31:0] o_data,
    output logic        o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    logic [31:0]      r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

// ===== sv/cas_back.sv =====
`timescale 1ns / 1ps

module cas_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  logic [31:0]   i_total,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output cas_pkg::t_out o_data
);

    localparam logic [3:0] BS_IDLE     = 4'd0;
    localparam logic [3:0] BS_DAY_EST  = 4'd1;
    localparam logic [3:0] BS_DAY_REM  = 4'd2;
    localparam logic [3:0] BS_HOUR_EST = 4'd3;
    localparam logic [3:0] BS_HOUR_REM = 4'd4;
    localparam logic [3:0] BS_MIN_EST  = 4'd5;
    localparam logic [3:0] BS_MIN_REM  = 4'd6;
    localparam logic [3:0] BS_YEAR     = 4'd7;
    localparam logic [3:0] BS_MONTH    = 4'd8;
    localparam logic [3:0] BS_DONE     = 4'd9;

    localparam logic [9:0] DAY_HI      = 10'd675;
    localparam logic [7:0] HOUR_HI     = 8'd225;
    localparam logic [3:0] MIN_HI      = 4'd15;

    logic [3:0]    r_state;
    logic          r_out_valid;
    cas_pkg::t_out r_out;

    logic [31:0]   r_total;
    logic [15:0]   r_qe;
    logic [10:0]   r_rr;
    logic [15:0]   r_days;
    logic [16:0]   r_rem;
    logic [4:0]    r_hq;
    logic [8:0]    r_hr;
    logic [4:0]    r_hour;
    logic [11:0]   r_rih;
    logic [5:0]    r_mq;
    logic [4:0]    r_mr;
    logic [2:0]    r_wday;
    logic [11:0]   r_year;
    logic [3:0]    r_month;

    logic [39:0]   w_dp;
    logic [24:0]   w_rr;
    logic [15:0]   w_days;
    logic [9:0]    w_rdr;
    logic [16:0]   w_rem;
    logic [21:0]   w_hp;
    logic [12:0]   w_hr;
    logic [7:0]    w_hrc;
    logic [11:0]   w_rih;
    logic [22:0]   w_mp;
    logic [9:0]    w_mr;
    logic          w_leap;
    logic [8:0]    w_ylen;
    logic [10:0]   w_blen;
    logic          w_take_blk;
    logic          w_take_year;
    logic [4:0]    w_mlen;
    logic          w_month_end;
    logic [5:0]    w_minute;
    logic [3:0]    w_mrc;
    logic          w_load;

    always_comb begin
        w_dp   = 40'(r_total[31:7]) * 40'(cas_pkg::RECIP_675);
        w_rr   = r_total[31:7] - 25'(26'(r_qe) * 26'(DAY_HI));
        w_days = (r_rr >= 11'(DAY_HI)) ? r_qe + 16'd1 : r_qe;
        w_rdr  = (r_rr >= 11'(DAY_HI)) ? 10'(r_rr - 11'(DAY_HI)) : 10'(r_rr);
        w_rem  = {w_rdr, r_total[6:0]};
        w_hp   = 22'(w_rem[16:4]) * 22'(cas_pkg::RECIP_225);
        w_hr   = r_rem[16:4] - 13'(13'(r_hq) * 13'(HOUR_HI));
        w_hrc  = (r_hr >= 9'(HOUR_HI)) ? 8'(r_hr - 9'(HOUR_HI)) : 8'(r_hr);
        w_rih  = {w_hrc, r_rem[3:0]};
        w_mp   = 23'(w_rih[11:2]) * 23'(cas_pkg::RECIP_15);
        w_mr   = r_rih[11:2] - 10'(10'(r_mq) * 10'(MIN_HI));

        // The year walk never leaves 2000..2136, where 2100 is the only
        // century year that is not a leap year.
        w_leap      = (r_year[1:0] == 2'd0) && (r_year != cas_pkg::CENTURY_YEAR);
        w_ylen      = w_leap ? cas_pkg::DAYS_LEAP_YEAR : cas_pkg::DAYS_PER_YEAR;
        w_blen      = (r_year == cas_pkg::CENTURY_YEAR) ?
                      cas_pkg::DAYS_SHORT_BLK : cas_pkg::DAYS_PER_BLOCK;
        w_take_blk  = (r_year[1:0] == 2'd0) && (r_days >= 16'(w_blen));
        w_take_year = (r_days >= 16'(w_ylen));
        w_mlen      = cas_pkg::month_len(r_month, w_leap);
        w_month_end = (r_days < 16'(w_mlen)) || (r_month >= cas_pkg::MONTH_DEC);

        w_minute = (r_mr >= 5'(MIN_HI)) ? r_mq + 6'd1 : r_mq;
        w_mrc    = (r_mr >= 5'(MIN_HI)) ? 4'(r_mr - 5'(MIN_HI)) : 4'(r_mr);
        w_load   = (r_state == BS_DONE) && (!r_out_valid || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                BS_IDLE: begin
                    if (!i_empty) begin
                        r_state <= BS_DAY_EST;
                    end
                end
                BS_DAY_EST:  r_state <= BS_DAY_REM;
                BS_DAY_REM:  r_state <= BS_HOUR_EST;
                BS_HOUR_EST: r_state <= BS_HOUR_REM;
                BS_HOUR_REM: r_state <= BS_MIN_EST;
                BS_MIN_EST:  r_state <= BS_MIN_REM;
                BS_MIN_REM:  r_state <= BS_YEAR;
                BS_YEAR: begin
                    if (!w_take_blk && !w_take_year) begin
                        r_state <= BS_MONTH;
                    end
                end
                BS_MONTH: begin
                    if (w_month_end) begin
                        r_state <= BS_DONE;
                    end
                end
                BS_DONE: begin
                    if (w_load) begin
                        r_state <= BS_IDLE;
                    end
                end
                default: r_state <= BS_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BS_IDLE: begin
                if (!i_empty) begin
                    r_total <= i_total;
                end
            end
            BS_DAY_EST: r_qe <= w_dp[39:24];
            BS_DAY_REM: r_rr <= 11'(w_rr);
            BS_HOUR_EST: begin
                r_days <= w_days;
                r_rem  <= w_rem;
                r_hq   <= w_hp[20:16];
            end
            BS_HOUR_REM: r_hr <= 9'(w_hr);
            BS_MIN_EST: begin
                r_hour <= (r_hr >= 9'(HOUR_HI)) ? r_hq + 5'd1 : r_hq;
                r_rih  <= w_rih;
                r_mq   <= w_mp[21:16];
            end
            BS_MIN_REM: begin
                r_mr    <= 5'(w_mr);
                r_wday  <= cas_pkg::mod7(17'(r_days) + 17'd5) + 3'd1;
                r_year  <= cas_pkg::EPOCH_YEAR;
                r_month <= cas_pkg::MONTH_JAN;
            end
            BS_YEAR: begin
                if (w_take_blk) begin
                    r_days <= r_days - 16'(w_blen);
                    r_year <= r_year + 12'd4;
                end else if (w_take_year) begin
                    r_days <= r_days - 16'(w_ylen);
                    r_year <= r_year + 12'd1;
                end
            end
            BS_MONTH: begin
                if (!w_month_end) begin
                    r_days  <= r_days - 16'(w_mlen);
                    r_month <= r_month + 4'd1;
                end
            end
            default: begin
            end
        endcase
        if (w_load) begin
            r_out.out_year      <= r_year;
            r_out.out_month     <= r_month;
            r_out.out_day       <= 5'(r_days + 16'd1);
            r_out.out_hour      <= r_hour;
            r_out.out_minute    <= w_minute;
            r_out.out_second    <= {w_mrc, r_rih[1:0]};
            r_out.out_weekday   <= r_wday;
            r_out.total_seconds <= r_total;
        end
    end

    assign o_pop   = (r_state == BS_IDLE) && !i_empty;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_YEAR) |-> (r_year <= cas_pkg::LAST_YEAR))
        else $error("year walk ran past the last reachable year");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.out_month >= cas_pkg::MONTH_JAN &&
                     o_data.out_month <= cas_pkg::MONTH_DEC))
        else $error("result month out of range");

    a_day_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_DONE) |-> (r_days < 16'(w_mlen)))
        else $error("day count exceeds month length");

endmodule

// ===== sv/calendar_add_seconds.sv =====
`timescale 1ns / 1ps

// Channel  Valid    Stall    Beat
// input    i_valid  o_stall  i_data (cas_pkg::t_in)
// output   o_valid  i_stall  o_data (cas_pkg::t_out)
//
// The front converts a date to seconds and hands the total to a small queue.
// The back splits each total into days and time of day through estimate and
// remainder states, then walks over four-year blocks, single years and
// months, one step per cycle; that walk sets the sustained rate.
// Reset is synchronous and active low; it empties the queue and the pipes.
// A stalled output holds its beat while the front and queue keep working.

module calendar_add_seconds #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  cas_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output cas_pkg::t_out o_data
);

    logic        w_push;
    logic [31:0] w_push_data;
    logic        w_full;
    logic        w_pop;
    logic [31:0] w_pop_data;
    logic        w_empty;

    cas_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_push  (w_push),
        .o_total (w_push_data),
        .i_full  (w_full)
    );

    cas_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_empty (w_empty)
    );

    cas_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_total (w_pop_data),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned SECS_DAY    = 86400;
    localparam int unsigned SECS_HOUR   = 3600;
    localparam int unsigned SECS_MIN    = 60;
    localparam int unsigned BASE_YEAR   = 2000;
    localparam int          TAIL_CYCLES = 150;
    localparam int          CYCLE_LIMIT = 1000000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    cas_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_stall;
    cas_pkg::t_out o_data;

    cas_pkg::t_out pending_dates[$];
    cas_pkg::t_out want_beat;
    int   mismatches;
    int   cycle_count;
    int   stall_left;
    bit   gaps_on;
    bit   stalls_on;

    calendar_add_seconds dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_of_month(int unsigned y, int unsigned m);
        if (m == 2 && leap_year(y)) begin
            return 29;
        end
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return 28;
            default:               return 0;
        endcase
    endfunction

    function automatic int unsigned month_key(int unsigned m);
        case (m)
            1, 5:    return 0;
            2, 6:    return 3;
            3, 11:   return 2;
            4, 7:    return 5;
            8:       return 1;
            9, 12:   return 4;
            10:      return 6;
            default: return 6;
        endcase
    endfunction

    function automatic cas_pkg::t_out predict_result(cas_pkg::t_in a);
        int unsigned y, mo, days, total, rem, ry, rm, wy, w, k;
        cas_pkg::t_out r;
        y = a.start_year;
        mo = a.start_month;
        days = 0;
        for (k = BASE_YEAR; k < y; k++) begin
            days += leap_year(k) ? 366 : 365;
        end
        for (k = 1; k < mo; k++) begin
            days += days_of_month(y, k);
        end
        days += 32'(a.start_day) - 1;
        total = days * SECS_DAY + 32'(a.start_hour) * SECS_HOUR
              + 32'(a.start_minute) * SECS_MIN + 32'(a.start_second) + a.offset_seconds;
        days = total / SECS_DAY;
        rem = total % SECS_DAY;
        ry = BASE_YEAR;
        rm = 1;
        while (days >= (leap_year(ry) ? 366 : 365)) begin
            days -= leap_year(ry) ? 366 : 365;
            ry++;
        end
        while (days >= days_of_month(ry, rm) && rm < 12) begin
            days -= days_of_month(ry, rm);
            rm++;
        end
        wy = (rm < 3) ? ry - 1 : ry;
        w = (wy + wy / 4 - wy / 100 + wy / 400 + month_key(rm) + days + 1) % 7;
        if (w == 0) begin
            w = 7;
        end
        r.out_year = 12'(ry);
        r.out_month = 4'(rm);
        r.out_day = 5'(days + 1);
        r.out_hour = 5'(rem / SECS_HOUR);
        rem = rem % SECS_HOUR;
        r.out_minute = 6'(rem / SECS_MIN);
        r.out_second = 6'(rem % SECS_MIN);
        r.out_weekday = 3'(w);
        r.total_seconds = total;
        return r;
    endfunction

    function automatic cas_pkg::t_in make_date(
        int unsigned y, int unsigned mo, int unsigned d,
        int unsigned h, int unsigned mi, int unsigned s,
        int unsigned off
    );
        cas_pkg::t_in a;
        a.start_year = 12'(y);
        a.start_month = 4'(mo);
        a.start_day = 5'(d);
        a.start_hour = 5'(h);
        a.start_minute = 6'(mi);
        a.start_second = 6'(s);
        a.offset_seconds = off;
        return a;
    endfunction

    function automatic int unsigned random_offset();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            return $urandom_range(0, 100000);
        end else if (pick < 6) begin
            return $urandom_range(0, SECS_DAY * 366 * 3);
        end else if (pick < 8) begin
            return $urandom;
        end
        return 32'hFFFF_FFFF - $urandom_range(0, SECS_DAY * 40);
    endfunction

    function automatic cas_pkg::t_in random_date();
        int unsigned y, mo;
        y = $urandom_range(BASE_YEAR, 2099);
        mo = $urandom_range(1, 12);
        return make_date(y, mo, $urandom_range(1, days_of_month(y, mo)),
                         $urandom_range(0, 23), $urandom_range(0, 59),
                         $urandom_range(0, 59), random_offset());
    endfunction

    function automatic int idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            return $urandom_range(1, 3);
        end else if (pick < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_date(input cas_pkg::t_in item);
        int idle;
        idle = (gaps_on && $urandom_range(0, 99) < 30) ? idle_length() : 0;
        @(negedge i_clk);
        if (idle != 0) begin
            i_valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= item;
        pending_dates.push_back(predict_result(item));
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic test_calendar_edges();
        send_date(make_date(2000, 1, 1, 0, 0, 0, 0));
        send_date(make_date(2099, 12, 31, 23, 59, 59, 0));
        send_date(make_date(2000, 1, 1, 0, 0, 0, 32'hFFFF_FFFF));
        send_date(make_date(2099, 12, 31, 23, 59, 59, 32'hFFFF_FFFF));
        send_date(make_date(2000, 2, 28, 23, 59, 59, 1));
        send_date(make_date(2096, 2, 28, 0, 0, 0, SECS_DAY));
        send_date(make_date(2099, 2, 28, 12, 0, 0, SECS_DAY));
        send_date(make_date(2099, 12, 31, 0, 0, 0, SECS_DAY * 60));
        send_date(make_date(2023, 12, 31, 23, 59, 59, 1));
        send_date(make_date(2024, 2, 29, 6, 30, 15, SECS_DAY * 365));
        send_date(make_date(2036, 7, 15, 8, 8, 8, 12345));
        send_date(make_date(2010, 10, 31, 23, 0, 0, 3600));
    endtask

    task automatic test_unchecked_fields();
        send_date(make_date(1999, 3, 1, 0, 0, 0, 0));
        send_date(make_date(1996, 3, 1, 1, 2, 3, 100));
        send_date(make_date(0, 1, 1, 0, 0, 0, 0));
        send_date(make_date(4095, 15, 31, 31, 63, 63, 32'hFFFF_FFFF));
        send_date(make_date(2100, 3, 1, 0, 0, 0, 0));
        send_date(make_date(2020, 0, 10, 0, 0, 0, 0));
        send_date(make_date(2020, 13, 1, 0, 0, 0, 0));
        send_date(make_date(2021, 15, 1, 0, 0, 0, 0));
        send_date(make_date(2000, 1, 0, 0, 0, 0, 0));
        send_date(make_date(2022, 4, 31, 0, 0, 0, 0));
        send_date(make_date(2015, 6, 10, 31, 63, 63, 0));
        send_date(make_date(2004, 2, 0, 0, 0, 0, 5));
    endtask

    task automatic test_random_dates(input int count);
        repeat (count) send_date(random_date());
    endtask

    task automatic test_raw_fields(input int count);
        cas_pkg::t_in a;
        repeat (count) begin
            a.start_year = 12'($urandom);
            a.start_month = 4'($urandom);
            a.start_day = 5'($urandom);
            a.start_hour = 5'($urandom);
            a.start_minute = 6'($urandom);
            a.start_second = 6'($urandom);
            a.offset_seconds = $urandom;
            send_date(a);
        end
    endtask

    task automatic test_back_to_back(input int count);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        repeat (count) send_date(random_date());
        wait_for_results();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else if (stalls_on && $urandom_range(0, 99) < 25) begin
            stall_left = idle_length() - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_dates.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing pending, actual %h", $time, o_data);
            end else begin
                want_beat = pending_dates.pop_front();
                check_field("out_year", 32'(want_beat.out_year), 32'(o_data.out_year));
                check_field("out_month", 32'(want_beat.out_month), 32'(o_data.out_month));
                check_field("out_day", 32'(want_beat.out_day), 32'(o_data.out_day));
                check_field("out_hour", 32'(want_beat.out_hour), 32'(o_data.out_hour));
                check_field("out_minute", 32'(want_beat.out_minute), 32'(o_data.out_minute));
                check_field("out_second", 32'(want_beat.out_second), 32'(o_data.out_second));
                check_field("out_weekday", 32'(want_beat.out_weekday),
                            32'(o_data.out_weekday));
                check_field("total_seconds", want_beat.total_seconds, o_data.total_seconds);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        stall_left = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_calendar_edges();
        test_unchecked_fields();
        wait_for_results();
        test_random_dates(400);
        wait_for_results();
        test_raw_fields(130);
        test_back_to_back(100);
        wait_for_results();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/cas_pkg.sv
sv/cas_front.sv
sv/cas_queue.sv
sv/cas_back.sv
sv/calendar_add_seconds.sv
tb/testbench.sv
